@@ hw/rtl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, character codes and helper functions of the source text
// tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Width of the internal byte offset counters; reported fields are 24 bits
  localparam int OFFSET_WIDTH = 24;
  localparam int FIELD_WIDTH  = 24;

  // Tokens produced by one input word, and the result queue behind them
  localparam int MAX_RESULTS = 4;
  localparam int TOK_IDX_W   = $clog2(MAX_RESULTS);
  localparam int WR_COUNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [OFFSET_WIDTH-1:0] offset_t;
  typedef logic [FIELD_WIDTH-1:0]  field_t;

  localparam offset_t OFF_MAX  = {OFFSET_WIDTH{1'b1}};
  localparam field_t  LINE_MAX = {FIELD_WIDTH{1'b1}};
  localparam field_t  LINE_ONE = field_t'(1);

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [3:0] {
    KIND_WORD    = 4'd0,
    KIND_STRING  = 4'd1,
    KIND_INT     = 4'd2,
    KIND_AT      = 4'd3,
    KIND_COMMENT = 4'd4,
    KIND_WS      = 4'd5,
    KIND_NL      = 4'd6,
    KIND_ERR     = 4'd7,
    KIND_END     = 4'd8
  } token_kind_t;

  typedef struct packed {
    token_kind_t kind;
    field_t      start;
    field_t      length;
    field_t      line;
    logic        last;
  } token_t;

  // Tokens raised by one input word, in order, with their number
  typedef struct packed {
    logic [WR_COUNT_W-1:0]        count;
    token_t [MAX_RESULTS-1:0]     tok;
  } scan_wr_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Space, tab, or a carriage return not followed by a line feed
  function automatic logic is_ws(logic [7:0] c, logic [7:0] n);
    return c == CH_SPACE || c == CH_TAB || (c == CH_CR && n != CH_LF);
  endfunction

  function automatic offset_t off_inc(offset_t v);
    return (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  function automatic field_t line_inc(field_t v);
    return (v == LINE_MAX) ? v : v + 1'b1;
  endfunction

  // Build a token from its bounds; length clamps at zero
  function automatic token_t make_tok(token_kind_t kind, offset_t s, offset_t e,
                                      field_t line);
    token_t  t;
    offset_t len;
    len      = (e >= s) ? e - s : '0;
    t.kind   = kind;
    t.start  = field_t'(s);
    t.length = field_t'(len);
    t.line   = line;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

@@ hw/rtl/stt_byte_if.sv @@
// ----------------------------------------------------------------------------
// stt_byte_if
// Valid/ready channel carrying one source text byte or an end mark.
// ----------------------------------------------------------------------------
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ hw/rtl/stt_token_if.sv @@
// ----------------------------------------------------------------------------
// stt_token_if
// Valid/ready channel carrying one token description.
// ----------------------------------------------------------------------------
interface stt_token_if
  import stt_pkg::*;
  ;
  logic        valid;
  logic        ready;
  token_kind_t token_kind;
  field_t      token_start;
  field_t      token_length;
  field_t      token_line;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output token_line, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input token_line, input last_of_run,
                output ready);
endinterface

@@ hw/rtl/stt_scan.sv @@
// ----------------------------------------------------------------------------
// stt_scan
// Token scanner: holds one byte of lookahead and the scan mode, and works
// out every token that the incoming word closes, in the same cycle.
// ----------------------------------------------------------------------------
module stt_scan
  import stt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output scan_wr_t   wr
);

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_STR,
    MODE_ESC,
    MODE_INT,
    MODE_COPEN,
    MODE_CBODY,
    MODE_CCLOSE,
    MODE_WS,
    MODE_CRLF
  } scan_mode_t;

  scan_mode_t scan_mode, scan_mode_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  offset_t    byte_offset, byte_offset_next;
  offset_t    start_offset, start_offset_next;
  field_t     line_count, line_count_next;
  field_t     start_line, start_line_next;

  logic                     ends;
  logic [7:0]               c;
  logic [7:0]               nb;
  logic                     do_begin;
  offset_t                  after;
  logic [WR_COUNT_W-1:0]    cnt;
  logic [TOK_IDX_W-1:0]     last_idx;
  token_t [MAX_RESULTS-1:0] tok_list;

  // Work out the next state and the tokens raised by this word
  always_comb begin
    ends     = end_of_text || (text_byte == CH_NUL);
    nb       = ends ? CH_NUL : text_byte;
    c        = held_byte;
    after    = off_inc(byte_offset);
    do_begin = 1'b0;
    cnt      = '0;
    tok_list = '0;
    last_idx = '0;

    scan_mode_next    = scan_mode;
    held_byte_next    = held_byte;
    held_valid_next   = held_valid;
    byte_offset_next  = byte_offset;
    start_offset_next = start_offset;
    line_count_next   = line_count;
    start_line_next   = start_line;

    // Advance the held byte with the new byte as lookahead
    if (held_valid) begin
      unique case (scan_mode)
        MODE_WORD: begin
          if (!is_alpha(c)) begin
            tok_list[cnt[TOK_IDX_W-1:0]] =
              make_tok(KIND_WORD, start_offset, byte_offset, start_line);
            cnt      = cnt + 1'b1;
            do_begin = 1'b1;
          end
        end
        MODE_INT: begin
          if (!is_digit(c)) begin
            tok_list[cnt[TOK_IDX_W-1:0]] =
              make_tok(KIND_INT, start_offset, byte_offset, start_line);
            cnt      = cnt + 1'b1;
            do_begin = 1'b1;
          end
        end
        MODE_WS: begin
          if (!is_ws(c, nb)) begin
            tok_list[cnt[TOK_IDX_W-1:0]] =
              make_tok(KIND_WS, start_offset, byte_offset, start_line);
            cnt      = cnt + 1'b1;
            do_begin = 1'b1;
          end
        end
        MODE_STR: begin
          if (c == CH_CR || c == CH_LF) begin
            // a line break cuts the string: swallow it into an error
            tok_list[cnt[TOK_IDX_W-1:0]] =
              make_tok(KIND_ERR, start_offset, after, start_line);
            cnt            = cnt + 1'b1;
            scan_mode_next = MODE_IDLE;
          end else if (c == CH_BSLASH) begin
            scan_mode_next = MODE_ESC;
          end else if (c == CH_QUOTE) begin
            tok_list[cnt[TOK_IDX_W-1:0]] =
              make_tok(KIND_STRING, start_offset, after, start_line);
            cnt            = cnt + 1'b1;
            scan_mode_next = MODE_IDLE;
          end
        end
        MODE_ESC:   scan_mode_next = MODE_STR;
        MODE_COPEN: scan_mode_next = MODE_CBODY;
        MODE_CBODY: begin
          if (c == CH_MINUS && nb == CH_RPAREN) begin
            scan_mode_next = MODE_CCLOSE;
          end
        end
        MODE_CCLOSE: begin
          tok_list[cnt[TOK_IDX_W-1:0]] =
            make_tok(KIND_COMMENT, start_offset, after, start_line);
          cnt            = cnt + 1'b1;
          scan_mode_next = MODE_IDLE;
        end
        MODE_CRLF: begin
          line_count_next = line_inc(line_count);
          tok_list[cnt[TOK_IDX_W-1:0]] =
            make_tok(KIND_NL, start_offset, after, start_line);
          cnt            = cnt + 1'b1;
          scan_mode_next = MODE_IDLE;
        end
        default: do_begin = 1'b1;
      endcase

      // Open a new token at the held byte
      if (do_begin) begin
        start_offset_next = byte_offset;
        start_line_next   = line_count_next;
        scan_mode_next    = MODE_IDLE;
        if (c == CH_LPAREN && nb == CH_MINUS) begin
          scan_mode_next = MODE_COPEN;
        end else if (c == CH_LF) begin
          line_count_next = line_inc(line_count_next);
          tok_list[cnt[TOK_IDX_W-1:0]] =
            make_tok(KIND_NL, byte_offset, after, start_line_next);
          cnt = cnt + 1'b1;
        end else if (c == CH_CR && nb == CH_LF) begin
          scan_mode_next = MODE_CRLF;
        end else if (is_ws(c, nb)) begin
          scan_mode_next = MODE_WS;
        end else if (is_digit(c) || (c == CH_MINUS && is_digit(nb))) begin
          scan_mode_next = MODE_INT;
        end else if (c == CH_QUOTE) begin
          scan_mode_next = MODE_STR;
        end else if (c == CH_AT) begin
          tok_list[cnt[TOK_IDX_W-1:0]] =
            make_tok(KIND_AT, byte_offset, after, start_line_next);
          cnt = cnt + 1'b1;
        end else if (is_alpha(c)) begin
          scan_mode_next = MODE_WORD;
        end else begin
          tok_list[cnt[TOK_IDX_W-1:0]] =
            make_tok(KIND_ERR, byte_offset, after, start_line_next);
          cnt = cnt + 1'b1;
        end
      end

      byte_offset_next = after;
    end

    if (ends) begin
      // Close whatever token is open at the end of the text
      unique case (scan_mode_next) inside
        MODE_WORD: begin
          tok_list[cnt[TOK_IDX_W-1:0]] =
            make_tok(KIND_WORD, start_offset_next, byte_offset_next, start_line_next);
          cnt = cnt + 1'b1;
        end
        MODE_INT: begin
          tok_list[cnt[TOK_IDX_W-1:0]] =
            make_tok(KIND_INT, start_offset_next, byte_offset_next, start_line_next);
          cnt = cnt + 1'b1;
        end
        MODE_WS: begin
          tok_list[cnt[TOK_IDX_W-1:0]] =
            make_tok(KIND_WS, start_offset_next, byte_offset_next, start_line_next);
          cnt = cnt + 1'b1;
        end
        MODE_STR, MODE_ESC: begin
          tok_list[cnt[TOK_IDX_W-1:0]] =
            make_tok(KIND_ERR, start_offset_next, byte_offset_next, start_line_next);
          cnt = cnt + 1'b1;
        end
        MODE_COPEN, MODE_CBODY, MODE_CCLOSE: begin
          // unterminated comment: the comment, then an empty error
          tok_list[cnt[TOK_IDX_W-1:0]] =
            make_tok(KIND_COMMENT, start_offset_next, byte_offset_next,
                     start_line_next);
          cnt = cnt + 1'b1;
          tok_list[cnt[TOK_IDX_W-1:0]] =
            make_tok(KIND_ERR, byte_offset_next, byte_offset_next, start_line_next);
          cnt = cnt + 1'b1;
        end
        MODE_CRLF: begin
          line_count_next = line_inc(line_count_next);
          tok_list[cnt[TOK_IDX_W-1:0]] =
            make_tok(KIND_NL, start_offset_next, byte_offset_next, start_line_next);
          cnt = cnt + 1'b1;
        end
        default: ;
      endcase

      tok_list[cnt[TOK_IDX_W-1:0]] =
        make_tok(KIND_END, byte_offset_next, byte_offset_next, line_count_next);
      cnt = cnt + 1'b1;

      // Start the next text afresh
      scan_mode_next    = MODE_IDLE;
      held_byte_next    = CH_NUL;
      held_valid_next   = 1'b0;
      byte_offset_next  = '0;
      start_offset_next = '0;
      line_count_next   = LINE_ONE;
      start_line_next   = LINE_ONE;
    end else begin
      held_byte_next  = text_byte;
      held_valid_next = 1'b1;
    end

    // Mark the final token of this word
    if (cnt != '0) begin
      last_idx = TOK_IDX_W'(cnt - 1'b1);
      tok_list[last_idx].last = 1'b1;
    end
  end

  assign wr.count = cnt;
  assign wr.tok   = tok_list;

  // Hold scanner state; advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode    <= MODE_IDLE;
      held_byte    <= CH_NUL;
      held_valid   <= 1'b0;
      byte_offset  <= '0;
      start_offset <= '0;
      line_count   <= LINE_ONE;
      start_line   <= LINE_ONE;
    end else if (accept) begin
      scan_mode    <= scan_mode_next;
      held_byte    <= held_byte_next;
      held_valid   <= held_valid_next;
      byte_offset  <= byte_offset_next;
      start_offset <= start_offset_next;
      line_count   <= line_count_next;
      start_line   <= start_line_next;
    end
  end

endmodule

@@ hw/rtl/stt_queue.sv @@
// ----------------------------------------------------------------------------
// stt_queue
// Result queue: takes up to four tokens at once from the scanner and hands
// them out one token per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module stt_queue
  import stt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  scan_wr_t    wr,
  output logic        room,
  stt_token_if.source tokens
);

  token_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   head;
  logic [QPTR_W-1:0]   tail;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;
  logic                pop;

  // Accept a word only while a full run of tokens still fits
  assign room = count <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);
  assign pop  = tokens.valid && tokens.ready;

  assign tokens.valid        = count != '0;
  assign tokens.token_kind   = entry[head].kind;
  assign tokens.token_start  = entry[head].start;
  assign tokens.token_length = entry[head].length;
  assign tokens.token_line   = entry[head].line;
  assign tokens.last_of_run  = entry[head].last;

  assign count_next = count + (push ? QCNT_W'(wr.count) : '0) - (pop ? QCNT_W'(1) : '0);

  // Store the run of tokens behind the tail
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (WR_COUNT_W'(i) < wr.count) begin
          entry[tail + QPTR_W'(i)] <= wr.tok[i];
        end
      end
    end
  end

  // Advance the pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        tail <= tail + QPTR_W'(wr.count);
      end
      if (pop) begin
        head <= head + 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/source_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-stream tokenizer for a simple source language.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle and splits the text into barewords,
// quoted strings, integers, at-signs, comments, whitespace runs, newlines,
// errors and an end token, each reported with kind, start offset, length and
// starting line. A token is decided one byte late, since the byte after it is
// needed; a zero byte or the end flag closes the text, flushes the open token
// and restarts offset and line counting. Each accepted byte raises zero to
// three tokens, computed in the same cycle and written at once into an
// eight-entry result queue that drains one token per cycle while the sink
// is ready; the last token of each byte's run carries last_of_run. Input is
// taken every cycle while the queue holds four tokens or fewer, so the
// sustained rate is one byte per cycle, limited by sink stalls and by the
// one-token-per-cycle output when bytes close several tokens. No start-up pass.
module source_text_tokenizer
  import stt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  stt_byte_if.sink    text,
  stt_token_if.source tokens
);

  logic     room;
  logic     accept;
  scan_wr_t wr;

  assign text.ready = room;
  assign accept     = text.valid && room;

  stt_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (text.text_byte),
    .end_of_text (text.end_of_text),
    .wr          (wr)
  );

  stt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .wr     (wr),
    .room   (room),
    .tokens (tokens)
  );

endmodule

@@ hw/rtl/stt_checker.sv @@
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the tokenizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module stt_checker
  import stt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input token_kind_t out_kind,
  input field_t      out_start,
  input field_t      out_length,
  input field_t      out_line,
  input logic        out_last
);

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token valid after reset");

  // The end token always closes its run
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_END |-> out_last)
    else $error("end token not last of run");

  // The end token is empty
  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_END |-> out_length == '0)
    else $error("end token with nonzero length");

  // Input stalls only while tokens are waiting
  a_stall_has_tokens: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty queue");

  // A stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_start)
      && $stable(out_length) && $stable(out_line) && $stable(out_last))
    else $error("stalled token changed");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (text.ready),
  .out_valid  (tokens.valid),
  .out_ready  (tokens.ready),
  .out_kind   (tokens.token_kind),
  .out_start  (tokens.token_start),
  .out_length (tokens.token_length),
  .out_line   (tokens.token_line),
  .out_last   (tokens.last_of_run)
);
